// ===== rtl/sitbt_pkg.sv =====
// ============================================================================
// sitbt_pkg
// Shared types and constants for the signed integer to base text converter.
// ============================================================================
package sitbt_pkg;

    // Input value and alphabet geometry
    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int ALPHA_CHARS  = 32;
    localparam int ALPHA_REGS   = 4;
    localparam int REG_W        = 64;
    localparam int APB_AW       = 5;

    // Base length counts up to ALPHA_CHARS, digit index addresses ALPHA_CHARS entries
    localparam int LEN_W        = $clog2(ALPHA_CHARS + 1);
    localparam int IDX_W        = $clog2(ALPHA_CHARS);

    // A 32-bit magnitude in base 2 has at most 32 digits
    localparam int MAX_DIGITS   = VALUE_W;
    localparam int ND_W         = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);

    // Divider: quotient bits resolved per cycle, divider steps per digit
    localparam int DIV_BITS_PER_CYC = 8;
    localparam int DIV_CYCLES       = VALUE_W / DIV_BITS_PER_CYC;
    localparam int STEP_W           = $clog2(DIV_CYCLES);

    localparam int MAX_BASE_LEN_DEF = 32;

    // Special characters
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Register indexes
    localparam logic [1:0] REG_CHARS_0  = 2'd0;
    localparam logic [1:0] REG_CHARS_8  = 2'd1;
    localparam logic [1:0] REG_CHARS_16 = 2'd2;
    localparam logic [1:0] REG_CHARS_24 = 2'd3;

    // Alphabet, character 0 in the low byte
    typedef logic [ALPHA_CHARS-1:0][CHAR_W-1:0] t_alpha;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic check;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_ok;
        logic char_bad;
        logic check_last;
        logic digit_fin;
        logic neg;
        logic out_free;
        logic last_digit;
    } t_sts;

endpackage

// ===== rtl/sitbt_regs.sv =====
// ============================================================================
// sitbt_regs
// APB alphabet registers and base length detection.
// ============================================================================
module sitbt_regs
    import sitbt_pkg::*;
#(
    parameter int MAX_BASE_LEN = MAX_BASE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [REG_W-1:0]  i_pwdata,
    output logic [REG_W-1:0]  o_prdata,
    output t_alpha            o_alpha,
    output logic [LEN_W-1:0]  o_len
);

    logic [ALPHA_REGS-1:0][REG_W-1:0] r_chars;
    logic [1:0]                       reg_idx;

    assign reg_idx = i_paddr[APB_AW-1:3];

    // Write a register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            r_chars[reg_idx] <= i_pwdata;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_CHARS_0:  o_prdata = r_chars[0];
            REG_CHARS_8:  o_prdata = r_chars[1];
            REG_CHARS_16: o_prdata = r_chars[2];
            REG_CHARS_24: o_prdata = r_chars[3];
            default:      o_prdata = '0;
        endcase
    end

    assign o_alpha = t_alpha'(r_chars);

    // Base length: first zero byte among the first MAX_BASE_LEN characters
    always_comb begin
        o_len = LEN_W'(MAX_BASE_LEN);
        for (int k = MAX_BASE_LEN - 1; k >= 0; k--) begin
            if (o_alpha[k] == '0) begin
                o_len = LEN_W'(k);
            end
        end
    end

endmodule

// ===== rtl/sitbt_dp.sv =====
// ============================================================================
// sitbt_dp
// Datapath: alphabet check, digit divider, digit stack and output register.
// ============================================================================
module sitbt_dp
    import sitbt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  t_alpha             i_alpha,
    input  logic [LEN_W-1:0]   i_len,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [CHAR_W-1:0]  o_m_tdata,
    output logic               o_m_tlast
);

    logic [VALUE_W-1:0]    r_work;
    logic                  r_neg;
    logic [IDX_W-1:0]      r_rem;
    logic [IDX_W-1:0]      r_idx;
    logic [STEP_W-1:0]     r_step;
    logic [ND_W-1:0]       r_nd;
    logic [CHAR_W-1:0]     r_dig [MAX_DIGITS];
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;

    logic [CHAR_W-1:0]     cur_char;
    logic                  dup;
    logic [VALUE_W-1:0]    div_work;
    logic [IDX_W-1:0]      div_rem;
    logic [IDX_W:0]        div_trial;
    logic                  step_last;
    logic [DIG_IDX_W-1:0]  rd_idx;
    logic                  out_free;

    // Alphabet check of one character against all later ones
    assign cur_char = i_alpha[r_idx];

    always_comb begin
        dup = 1'b0;
        for (int b = 0; b < ALPHA_CHARS; b++) begin
            if ((LEN_W'(b) > {1'b0, r_idx}) && (LEN_W'(b) < i_len)
                    && (i_alpha[b] == cur_char)) begin
                dup = 1'b1;
            end
        end
    end

    // Restoring division, DIV_BITS_PER_CYC quotient bits per cycle
    always_comb begin
        div_work  = r_work;
        div_rem   = r_rem;
        div_trial = '0;
        for (int s = 0; s < DIV_BITS_PER_CYC; s++) begin
            div_trial = {div_rem, div_work[VALUE_W-1]};
            div_work  = {div_work[VALUE_W-2:0], 1'b0};
            if (LEN_W'(div_trial) >= i_len) begin
                div_trial   = div_trial - (IDX_W+1)'(i_len);
                div_work[0] = 1'b1;
            end
            div_rem = div_trial[IDX_W-1:0];
        end
    end

    assign step_last = (r_step == STEP_W'(DIV_CYCLES - 1));
    assign rd_idx    = DIG_IDX_W'(r_nd - ND_W'(1));
    assign out_free  = !r_out_valid || i_m_tready;

    // Status to the controller
    always_comb begin
        o_sts.len_ok     = (i_len >= LEN_W'(2));
        o_sts.char_bad   = (cur_char == CHAR_PLUS) || (cur_char == CHAR_MINUS) || dup;
        o_sts.check_last = ({1'b0, r_idx} == (i_len - LEN_W'(1)));
        o_sts.digit_fin  = step_last
                           && ((div_work == '0) || (r_nd == ND_W'(MAX_DIGITS - 1)));
        o_sts.neg        = r_neg;
        o_sts.out_free   = out_free;
        o_sts.last_digit = (r_nd == ND_W'(1));
    end

    // Item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[VALUE_W-1];
            r_work <= i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            r_rem  <= '0;
            r_idx  <= '0;
            r_step <= '0;
            r_nd   <= '0;
        end else if (i_cmd.check) begin
            r_idx <= r_idx + IDX_W'(1);
        end else if (i_cmd.div) begin
            r_work <= div_work;
            if (step_last) begin
                r_dig[r_nd[DIG_IDX_W-1:0]] <= i_alpha[div_rem];
                r_nd   <= r_nd + ND_W'(1);
                r_rem  <= '0;
                r_step <= '0;
            end else begin
                r_rem  <= div_rem;
                r_step <= r_step + STEP_W'(1);
            end
        end else if (i_cmd.emit_digit) begin
            r_nd <= r_nd - ND_W'(1);
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= r_dig[rd_idx];
            r_out_last <= (r_nd == ND_W'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/sitbt_ctrl.sv =====
// ============================================================================
// sitbt_ctrl
// Controller: sequences alphabet check, digit division and character output.
// ============================================================================
module sitbt_ctrl
    import sitbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // Commands
    always_comb begin
        o_cmd.load       = accept;
        o_cmd.check      = (r_state == S_CHECK);
        o_cmd.div        = (r_state == S_DIV);
        o_cmd.emit_sign  = (r_state == S_SIGN) && i_sts.out_free;
        o_cmd.emit_digit = (r_state == S_EMIT) && i_sts.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_sts.len_ok) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.char_bad) begin
                    n_state = S_IDLE;
                end else if (i_sts.check_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.digit_fin) begin
                    n_state = i_sts.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/signed_int_to_base_text.sv =====
// ============================================================================
// signed_int_to_base_text
// Converts a signed 32-bit value to text in the radix of a configured alphabet.
// ============================================================================
// Per item: alphabet check, then digit division, then the characters (sign
// and digits) while the output is free. Items with an invalid alphabet
// are dropped without output.
// Reset clears the alphabet to zero, the controller to idle, the output empty.
module signed_int_to_base_text
    import sitbt_pkg::*;
#(
    parameter int MAX_BASE_LEN = MAX_BASE_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [31:0] value
    // Output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,    // [7:0] character
    output logic               m_tlast,    // last_char
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready
);

    t_alpha           alpha;
    logic [LEN_W-1:0] len;
    t_cmd             cmd;
    t_sts             sts;

    assign pready = 1'b1;

    sitbt_regs #(
        .MAX_BASE_LEN (MAX_BASE_LEN)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_alpha   (alpha),
        .o_len     (len)
    );

    sitbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sitbt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (s_tdata),
        .i_alpha    (alpha),
        .i_len      (len),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/sitbt_checker.sv =====
// ============================================================================
// sitbt_checker
// Port-level checks of the converter, bound to the top level.
// ============================================================================
module sitbt_checker
    import sitbt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast
);

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // Stalled transaction holds its character
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // Minus sign never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign marked last");

    // No new item while a number is still being emitted
    a_no_accept_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a number");

endmodule

bind signed_int_to_base_text sitbt_checker u_sitbt_checker (.*);
